>>> hw/rtl/nfca_pkg.sv
package nfca_pkg;

  localparam int ZONE_GRANULES   = 65536;
  localparam int HEADER_GRANULES = 4;
  localparam int SPLIT_MIN_BYTES = 64;
  localparam int GUARD_BYTES     = 4;

  localparam int IDX_W = $clog2(ZONE_GRANULES);
  localparam int POS_W = IDX_W + 1;
  localparam int LEN_W = POS_W;
  localparam int REQ_W = 19;
  localparam int LAP_W = POS_W + 1;

  localparam logic [POS_W-1:0] END_CAP = POS_W'(ZONE_GRANULES);
  localparam logic [LEN_W-1:0] SPLIT_MIN_GRAN = LEN_W'(SPLIT_MIN_BYTES / 8);
  localparam logic [REQ_W:0] NEED_BIAS = (REQ_W+1)'(HEADER_GRANULES * 8 + GUARD_BYTES + 7);
  localparam logic [LAP_W-1:0] LAP_LIMIT = LAP_W'(ZONE_GRANULES + 2);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_NOT_START    = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE,
    S_A_RD0, S_A_INIT, S_A_STEP, S_A_RD, S_A_CHK,
    S_A_FOUND, S_A_TAIL, S_A_AFTER, S_A_WT, S_A_WA, S_A_WC, S_A_RV,
    S_F_RD, S_F_CHK, S_F_CLR, S_F_PRD, S_F_PCK, S_F_PAF, S_F_PSUM,
    S_F_PW1, S_F_PW2, S_F_PW3, S_F_NX, S_F_NRD, S_F_NCK, S_F_NAF,
    S_F_NSUM, S_F_NW1, S_F_NW2, S_F_NW3
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr;
    logic             we_len;
    logic             we_prev;
    logic             we_use;
    logic             we_mark;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] prev;
    logic             use_bit;
    logic             mark;
  } mem_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] prev;
    logic             use_bit;
    logic             mark;
  } mem_rd_t;

  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W:0] v);
    logic [POS_W-1:0] r;
    if (v > {1'b0, END_CAP}) begin
      r = END_CAP;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/nfca_mem.sv
module nfca_mem (
  input  logic               clk,
  input  nfca_pkg::mem_req_t req,
  output nfca_pkg::mem_rd_t  rd
);

  logic [nfca_pkg::LEN_W-1:0] len_mem  [nfca_pkg::ZONE_GRANULES];
  logic [nfca_pkg::POS_W-1:0] prev_mem [nfca_pkg::ZONE_GRANULES];
  logic                       use_mem  [nfca_pkg::ZONE_GRANULES];
  logic                       mark_mem [nfca_pkg::ZONE_GRANULES];
  nfca_pkg::mem_rd_t          rd_r;

  always_ff @(posedge clk) begin
    if (req.we_len) begin
      len_mem[req.addr] <= req.len;
    end
    if (req.we_prev) begin
      prev_mem[req.addr] <= req.prev;
    end
    if (req.we_use) begin
      use_mem[req.addr] <= req.use_bit;
    end
    if (req.we_mark) begin
      mark_mem[req.addr] <= req.mark;
    end
    rd_r.len     <= len_mem[req.addr];
    rd_r.prev    <= prev_mem[req.addr];
    rd_r.use_bit <= use_mem[req.addr];
    rd_r.mark    <= mark_mem[req.addr];
  end

  assign rd = rd_r;

endmodule

>>> hw/rtl/nfca_alu.sv
module nfca_alu (
  input  logic [nfca_pkg::POS_W-1:0] a,
  input  logic [nfca_pkg::POS_W-1:0] b,
  input  nfca_pkg::alu_op_t          op,
  output logic [nfca_pkg::POS_W:0]   y,
  output logic [nfca_pkg::POS_W-1:0] y_clamp
);

  always_comb begin
    if (op == nfca_pkg::ALU_SUB) begin
      y = {1'b0, a} - {1'b0, b};
    end else begin
      y = {1'b0, a} + {1'b0, b};
    end
    y_clamp = nfca_pkg::clamp_pos(y);
  end

endmodule

>>> hw/rtl/nfca_seq.sv
module nfca_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [nfca_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [nfca_pkg::IDX_W-1:0]   in_free_address,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [nfca_pkg::IDX_W-1:0]   out_granted_address,
  output logic [nfca_pkg::LEN_W-1:0]   out_granted_granules,
  output nfca_pkg::mem_req_t           mem_req,
  input  nfca_pkg::mem_rd_t            mem_rd,
  output logic [nfca_pkg::POS_W-1:0]   alu_a,
  output logic [nfca_pkg::POS_W-1:0]   alu_b,
  output nfca_pkg::alu_op_t            alu_op,
  input  logic [nfca_pkg::POS_W:0]     alu_y,
  input  logic [nfca_pkg::POS_W-1:0]   alu_yc
);

  localparam int IDX_W = nfca_pkg::IDX_W;
  localparam int POS_W = nfca_pkg::POS_W;
  localparam int LEN_W = nfca_pkg::LEN_W;
  localparam int LAP_W = nfca_pkg::LAP_W;

  nfca_pkg::state_t state_r, state_nxt;

  logic [POS_W-1:0] rover_r, end_prev_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [IDX_W-1:0] out_addr_r;
  logic [LEN_W-1:0] out_gran_r;

  logic [LEN_W-1:0] need_r, cand_len_r, sc_len_r, spare_r, fin_len_r;
  logic [LEN_W-1:0] blk_len_r, nb_len_r, sum_r;
  logic [POS_W-1:0] cand_r, scan_r, stop_r, after_r, nb_r;
  logic [IDX_W-1:0] tail_r, blk_r;
  logic             cand_use_r, sc_use_r, split_r, rd_end_r;
  logic [LAP_W-1:0] laps_r;

  logic [POS_W-1:0]   rd_pos;
  logic               eff_use;
  logic [LEN_W-1:0]   eff_len;
  logic [POS_W-1:0]   eff_prev;
  logic               ce_use;
  logic [LEN_W-1:0]   ce_len;
  logic               fit;
  logic               lap_fail;
  logic [POS_W-1:0]   nscan;
  logic [nfca_pkg::REQ_W:0] need_sum;
  logic               res_fire;
  nfca_pkg::status_t  res_status;
  logic [IDX_W-1:0]   res_addr;
  logic [LEN_W-1:0]   res_gran;

  // end cap is not in the memory: always in use, zero length
  assign eff_use  = rd_end_r | mem_rd.use_bit;
  assign eff_len  = rd_end_r ? '0 : mem_rd.len;
  assign eff_prev = rd_end_r ? end_prev_r : mem_rd.prev;

  assign ce_use   = (cand_r == scan_r) ? eff_use : cand_use_r;
  assign ce_len   = (cand_r == scan_r) ? eff_len : cand_len_r;
  assign fit      = !ce_use && (ce_len >= need_r);
  assign lap_fail = (scan_r == stop_r) || (laps_r > nfca_pkg::LAP_LIMIT);
  assign nscan    = (scan_r == nfca_pkg::END_CAP) ? '0 : alu_yc;
  assign need_sum = {1'b0, in_request_bytes} + nfca_pkg::NEED_BIAS;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfca_pkg::S_CLEAR: begin
        if (clr_cnt_r == '1) state_nxt = nfca_pkg::S_IDLE;
      end
      nfca_pkg::S_IDLE: begin
        if (start) begin
          if (in_kind == nfca_pkg::KIND_FREE) begin
            if (in_free_address >= IDX_W'(nfca_pkg::HEADER_GRANULES)) begin
              state_nxt = nfca_pkg::S_F_RD;
            end
          end else begin
            state_nxt = nfca_pkg::S_A_RD0;
          end
        end
      end
      nfca_pkg::S_A_RD0:  state_nxt = nfca_pkg::S_A_INIT;
      nfca_pkg::S_A_INIT: state_nxt = nfca_pkg::S_A_STEP;
      nfca_pkg::S_A_STEP: state_nxt = lap_fail ? nfca_pkg::S_IDLE : nfca_pkg::S_A_RD;
      nfca_pkg::S_A_RD:   state_nxt = nfca_pkg::S_A_CHK;
      nfca_pkg::S_A_CHK:  state_nxt = fit ? nfca_pkg::S_A_FOUND : nfca_pkg::S_A_STEP;
      nfca_pkg::S_A_FOUND: begin
        state_nxt = (alu_y[LEN_W-1:0] > nfca_pkg::SPLIT_MIN_GRAN) ?
                    nfca_pkg::S_A_TAIL : nfca_pkg::S_A_WC;
      end
      nfca_pkg::S_A_TAIL:  state_nxt = nfca_pkg::S_A_AFTER;
      nfca_pkg::S_A_AFTER: state_nxt = nfca_pkg::S_A_WT;
      nfca_pkg::S_A_WT:    state_nxt = nfca_pkg::S_A_WA;
      nfca_pkg::S_A_WA:    state_nxt = nfca_pkg::S_A_WC;
      nfca_pkg::S_A_WC:    state_nxt = nfca_pkg::S_A_RV;
      nfca_pkg::S_A_RV:    state_nxt = nfca_pkg::S_IDLE;
      nfca_pkg::S_F_RD:    state_nxt = nfca_pkg::S_F_CHK;
      nfca_pkg::S_F_CHK: begin
        state_nxt = (mem_rd.mark && mem_rd.use_bit) ? nfca_pkg::S_F_CLR : nfca_pkg::S_IDLE;
      end
      nfca_pkg::S_F_CLR:  state_nxt = nfca_pkg::S_F_PRD;
      nfca_pkg::S_F_PRD:  state_nxt = nfca_pkg::S_F_PCK;
      nfca_pkg::S_F_PCK:  state_nxt = eff_use ? nfca_pkg::S_F_NX : nfca_pkg::S_F_PAF;
      nfca_pkg::S_F_PAF:  state_nxt = nfca_pkg::S_F_PSUM;
      nfca_pkg::S_F_PSUM: state_nxt = nfca_pkg::S_F_PW1;
      nfca_pkg::S_F_PW1:  state_nxt = nfca_pkg::S_F_PW2;
      nfca_pkg::S_F_PW2:  state_nxt = nfca_pkg::S_F_PW3;
      nfca_pkg::S_F_PW3:  state_nxt = nfca_pkg::S_F_NX;
      nfca_pkg::S_F_NX:   state_nxt = nfca_pkg::S_F_NRD;
      nfca_pkg::S_F_NRD:  state_nxt = nfca_pkg::S_F_NCK;
      nfca_pkg::S_F_NCK:  state_nxt = eff_use ? nfca_pkg::S_IDLE : nfca_pkg::S_F_NAF;
      nfca_pkg::S_F_NAF:  state_nxt = nfca_pkg::S_F_NSUM;
      nfca_pkg::S_F_NSUM: state_nxt = nfca_pkg::S_F_NW1;
      nfca_pkg::S_F_NW1:  state_nxt = nfca_pkg::S_F_NW2;
      nfca_pkg::S_F_NW2:  state_nxt = nfca_pkg::S_F_NW3;
      nfca_pkg::S_F_NW3:  state_nxt = nfca_pkg::S_IDLE;
      default:            state_nxt = nfca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_req    = '0;
    rd_pos     = '0;
    alu_a      = '0;
    alu_b      = '0;
    alu_op     = nfca_pkg::ALU_ADD;
    res_fire   = 1'b0;
    res_status = nfca_pkg::ST_OK;
    res_addr   = '0;
    res_gran   = '0;
    case (state_r)
      nfca_pkg::S_CLEAR: begin
        mem_req.addr    = clr_cnt_r;
        mem_req.we_len  = 1'b1;
        mem_req.we_prev = 1'b1;
        mem_req.we_use  = 1'b1;
        mem_req.we_mark = 1'b1;
        if (clr_cnt_r == '0) begin
          mem_req.len  = LEN_W'(nfca_pkg::ZONE_GRANULES);
          mem_req.prev = nfca_pkg::END_CAP;
          mem_req.mark = 1'b1;
        end
      end
      nfca_pkg::S_IDLE: begin
        if (start && in_kind == nfca_pkg::KIND_FREE &&
            in_free_address < IDX_W'(nfca_pkg::HEADER_GRANULES)) begin
          res_fire   = 1'b1;
          res_status = nfca_pkg::ST_NOT_START;
        end
      end
      nfca_pkg::S_A_RD0: rd_pos = rover_r;
      nfca_pkg::S_A_STEP: begin
        alu_a = scan_r;
        alu_b = sc_len_r;
        if (lap_fail) begin
          res_fire   = 1'b1;
          res_status = nfca_pkg::ST_NO_SPACE;
        end
      end
      nfca_pkg::S_A_RD: rd_pos = scan_r;
      nfca_pkg::S_A_FOUND: begin
        alu_a  = cand_len_r;
        alu_b  = need_r;
        alu_op = nfca_pkg::ALU_SUB;
      end
      nfca_pkg::S_A_TAIL: begin
        alu_a = cand_r;
        alu_b = need_r;
      end
      nfca_pkg::S_A_AFTER: begin
        alu_a = cand_r;
        alu_b = cand_len_r;
      end
      nfca_pkg::S_A_WT: begin
        mem_req.addr    = tail_r;
        mem_req.we_len  = 1'b1;
        mem_req.we_prev = 1'b1;
        mem_req.we_use  = 1'b1;
        mem_req.we_mark = 1'b1;
        mem_req.len     = spare_r;
        mem_req.prev    = cand_r;
        mem_req.mark    = 1'b1;
      end
      nfca_pkg::S_A_WA: begin
        mem_req.addr    = after_r[IDX_W-1:0];
        mem_req.we_prev = (after_r != nfca_pkg::END_CAP);
        mem_req.prev    = {1'b0, tail_r};
      end
      nfca_pkg::S_A_WC: begin
        mem_req.addr    = cand_r[IDX_W-1:0];
        mem_req.we_use  = 1'b1;
        mem_req.use_bit = 1'b1;
        mem_req.we_len  = split_r;
        mem_req.len     = need_r;
      end
      nfca_pkg::S_A_RV: begin
        alu_a      = cand_r;
        alu_b      = fin_len_r;
        res_fire   = 1'b1;
        res_addr   = cand_r[IDX_W-1:0] + IDX_W'(nfca_pkg::HEADER_GRANULES);
        res_gran   = fin_len_r;
      end
      nfca_pkg::S_F_RD: begin
        mem_req.addr = blk_r;
        rd_pos       = {1'b0, blk_r};
      end
      nfca_pkg::S_F_CHK: begin
        if (!mem_rd.mark) begin
          res_fire   = 1'b1;
          res_status = nfca_pkg::ST_NOT_START;
        end else if (!mem_rd.use_bit) begin
          res_fire   = 1'b1;
          res_status = nfca_pkg::ST_ALREADY_FREE;
        end
      end
      nfca_pkg::S_F_CLR: begin
        mem_req.addr   = blk_r;
        mem_req.we_use = 1'b1;
      end
      nfca_pkg::S_F_PRD, nfca_pkg::S_F_NRD: begin
        mem_req.addr = nb_r[IDX_W-1:0];
        rd_pos       = nb_r;
      end
      nfca_pkg::S_F_PAF, nfca_pkg::S_F_NX: begin
        alu_a = {1'b0, blk_r};
        alu_b = blk_len_r;
      end
      nfca_pkg::S_F_PSUM, nfca_pkg::S_F_NSUM: begin
        alu_a = nb_len_r;
        alu_b = blk_len_r;
      end
      nfca_pkg::S_F_PW1: begin
        mem_req.addr   = nb_r[IDX_W-1:0];
        mem_req.we_len = 1'b1;
        mem_req.len    = sum_r;
      end
      nfca_pkg::S_F_PW2: begin
        mem_req.addr    = after_r[IDX_W-1:0];
        mem_req.we_prev = (after_r != nfca_pkg::END_CAP);
        mem_req.prev    = nb_r;
      end
      nfca_pkg::S_F_PW3: begin
        mem_req.addr    = blk_r;
        mem_req.we_mark = 1'b1;
      end
      nfca_pkg::S_F_NCK: begin
        if (eff_use) res_fire = 1'b1;
      end
      nfca_pkg::S_F_NAF: begin
        alu_a = nb_r;
        alu_b = nb_len_r;
      end
      nfca_pkg::S_F_NW1: begin
        mem_req.addr   = blk_r;
        mem_req.we_len = 1'b1;
        mem_req.len    = sum_r;
      end
      nfca_pkg::S_F_NW2: begin
        mem_req.addr    = after_r[IDX_W-1:0];
        mem_req.we_prev = (after_r != nfca_pkg::END_CAP);
        mem_req.prev    = {1'b0, blk_r};
      end
      nfca_pkg::S_F_NW3: begin
        mem_req.addr    = nb_r[IDX_W-1:0];
        mem_req.we_mark = 1'b1;
        res_fire        = 1'b1;
      end
      default: ;
    endcase
    // reads use the same address port
    if (state_r == nfca_pkg::S_A_RD0 || state_r == nfca_pkg::S_A_RD) begin
      mem_req.addr = rd_pos[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfca_pkg::S_CLEAR;
      rover_r     <= '0;
      end_prev_r  <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_fire;
      if (state_r == nfca_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      case (state_r)
        nfca_pkg::S_A_RV: rover_r <= alu_yc;
        nfca_pkg::S_A_WA: begin
          if (after_r == nfca_pkg::END_CAP) end_prev_r <= {1'b0, tail_r};
        end
        nfca_pkg::S_F_PW2: begin
          if (after_r == nfca_pkg::END_CAP) end_prev_r <= nb_r;
        end
        nfca_pkg::S_F_PW3: begin
          if (rover_r == {1'b0, blk_r}) rover_r <= nb_r;
        end
        nfca_pkg::S_F_NW2: begin
          if (after_r == nfca_pkg::END_CAP) end_prev_r <= {1'b0, blk_r};
        end
        nfca_pkg::S_F_NW3: begin
          if (rover_r == nb_r) rover_r <= {1'b0, blk_r};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_end_r <= (rd_pos == nfca_pkg::END_CAP);
    if (res_fire) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_gran_r   <= res_gran;
    end
    case (state_r)
      nfca_pkg::S_IDLE: begin
        need_r <= LEN_W'(need_sum >> 3);
        blk_r  <= in_free_address - IDX_W'(nfca_pkg::HEADER_GRANULES);
        laps_r <= '0;
        cand_r <= rover_r;
        scan_r <= rover_r;
      end
      nfca_pkg::S_A_INIT: begin
        stop_r     <= nfca_pkg::clamp_pos({1'b0, eff_prev});
        sc_use_r   <= eff_use;
        sc_len_r   <= eff_len;
        cand_use_r <= eff_use;
        cand_len_r <= eff_len;
      end
      nfca_pkg::S_A_STEP: begin
        laps_r <= laps_r + 1'b1;
        scan_r <= nscan;
        if (sc_use_r) cand_r <= nscan;
      end
      nfca_pkg::S_A_CHK: begin
        sc_use_r   <= eff_use;
        sc_len_r   <= eff_len;
        cand_use_r <= ce_use;
        cand_len_r <= ce_len;
      end
      nfca_pkg::S_A_FOUND: begin
        spare_r <= alu_y[LEN_W-1:0];
        split_r <= (alu_y[LEN_W-1:0] > nfca_pkg::SPLIT_MIN_GRAN);
      end
      nfca_pkg::S_A_TAIL:  tail_r  <= alu_y[IDX_W-1:0];
      nfca_pkg::S_A_AFTER: after_r <= alu_yc;
      nfca_pkg::S_A_WC:    fin_len_r <= split_r ? need_r : cand_len_r;
      nfca_pkg::S_F_CHK: begin
        blk_len_r <= mem_rd.len;
        nb_r      <= nfca_pkg::clamp_pos({1'b0, mem_rd.prev});
      end
      nfca_pkg::S_F_PCK, nfca_pkg::S_F_NCK: nb_len_r <= eff_len;
      nfca_pkg::S_F_PAF, nfca_pkg::S_F_NAF: after_r <= alu_yc;
      nfca_pkg::S_F_PSUM, nfca_pkg::S_F_NSUM: sum_r <= alu_y[LEN_W-1:0];
      nfca_pkg::S_F_PW3: begin
        blk_r     <= nb_r[IDX_W-1:0];
        blk_len_r <= sum_r;
      end
      nfca_pkg::S_F_NX: nb_r <= alu_yc;
      default: ;
    endcase
  end

  assign busy                 = (state_r != nfca_pkg::S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_granted_address  = out_addr_r;
  assign out_granted_granules = out_gran_r;

`ifndef NO_ASSERTIONS
  a_rover_in_zone: assert property (@(posedge clk) disable iff (!rst_n)
    rover_r <= nfca_pkg::END_CAP)
    else $error("rover beyond end cap");

  a_found_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nfca_pkg::S_A_FOUND |-> !cand_use_r && cand_r != nfca_pkg::END_CAP)
    else $error("allocation picked a used block");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nfca_pkg::S_IDLE |->
      !(mem_req.we_len || mem_req.we_prev || mem_req.we_use || mem_req.we_mark))
    else $error("memory write while idle");

  a_result_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> state_r == nfca_pkg::S_IDLE)
    else $error("result issued mid operation");
`endif

endmodule

>>> hw/rtl/next_fit_coalescing_allocator.sv
// Next-fit block allocator with coalescing over a zone of 8-byte granules.
// Command channel: an item transfers on a rising edge with start high and
// busy low. in_kind selects allocate (in_request_bytes) or free
// (in_free_address, the user-data granule returned by an allocate).
// Result channel: each command yields exactly one result, shown for one
// cycle with out_valid high; the receiver cannot stall it. out_status is
// ok, no space, not a block start or already free; address and length are
// zero except on a good allocate.
// Timing: busy falls in the cycle the result strobe rises. An allocate
// fetches the rover header, checks one header at a time, then commits
// (writing a tail header when a free tail is split off); a failed search
// checks each block once around the zone. A free reads its header and is
// rejected there, or clears it and merges with a free previous block and
// a free next block; a free address below the header gets its result in
// the cycle after the transfer. The pace is set by the single-port header
// memory: every header access is one read or one write, and block sums go
// through one shared adder. Reset: the header memory is initialized by a
// clearing pass (one entry per cycle) during which busy is high.
module next_fit_coalescing_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic [nfca_pkg::REQ_W-1:0]     in_request_bytes,
  input  logic [nfca_pkg::IDX_W-1:0]     in_free_address,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [nfca_pkg::IDX_W-1:0]     out_granted_address,
  output logic [nfca_pkg::LEN_W-1:0]     out_granted_granules
);

  nfca_pkg::mem_req_t          mem_req;
  nfca_pkg::mem_rd_t           mem_rd;
  logic [nfca_pkg::POS_W-1:0]  alu_a, alu_b, alu_yc;
  logic [nfca_pkg::POS_W:0]    alu_y;
  nfca_pkg::alu_op_t           alu_op;

  nfca_seq u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_kind              (in_kind),
    .in_request_bytes     (in_request_bytes),
    .in_free_address      (in_free_address),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_granted_address  (out_granted_address),
    .out_granted_granules (out_granted_granules),
    .mem_req              (mem_req),
    .mem_rd               (mem_rd),
    .alu_a                (alu_a),
    .alu_b                (alu_b),
    .alu_op               (alu_op),
    .alu_y                (alu_y),
    .alu_yc               (alu_yc)
  );

  nfca_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rd  (mem_rd)
  );

  nfca_alu u_alu (
    .a       (alu_a),
    .b       (alu_b),
    .op      (alu_op),
    .y       (alu_y),
    .y_clamp (alu_yc)
  );

endmodule

>>> verif/next_fit_coalescing_allocator_checker.sv
module next_fit_coalescing_allocator_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_kind,
  input  logic [nfca_pkg::REQ_W-1:0] in_request_bytes,
  input  logic [nfca_pkg::IDX_W-1:0] in_free_address,
  input  logic                       out_valid,
  input  logic [1:0]                 out_status,
  input  logic [nfca_pkg::IDX_W-1:0] out_granted_address,
  input  logic [nfca_pkg::LEN_W-1:0] out_granted_granules,
  output int                         errors,
  output int                         waiting,
  output int                         n_granted,
  output int                         n_no_space,
  output int                         n_freed,
  output int                         n_rejected
);

  localparam int ZONE  = nfca_pkg::ZONE_GRANULES;
  localparam int IDX_W = nfca_pkg::IDX_W;
  localparam int LEN_W = nfca_pkg::LEN_W;

  typedef struct {
    nfca_pkg::status_t status;
    logic [IDX_W-1:0]  addr;
    logic [LEN_W-1:0]  gran;
  } grant_t;

  int unsigned blk_len[0:ZONE];
  bit          blk_used[0:ZONE];
  int unsigned blk_prev[0:ZONE];
  bit          blk_mark[0:ZONE];
  int unsigned rover;
  grant_t      pending_grants[$];

  initial begin
    errors = 0;
    n_granted = 0;
    n_no_space = 0;
    n_freed = 0;
    n_rejected = 0;
    for (int i = 0; i <= ZONE; i++) begin
      blk_len[i] = 0;
      blk_used[i] = 0;
      blk_prev[i] = 0;
      blk_mark[i] = 0;
    end
    blk_len[0] = ZONE;
    blk_prev[0] = ZONE;
    blk_mark[0] = 1;
    blk_used[ZONE] = 1;
    rover = 0;
  end

  assign waiting = pending_grants.size();

  function automatic int unsigned clip(int unsigned p);
    return (p > ZONE) ? ZONE : p;
  endfunction

  function automatic int unsigned next_blk(int unsigned p);
    p = clip(p);
    if (p == ZONE) return 0;
    return clip(p + blk_len[p]);
  endfunction

  function automatic int unsigned prev_blk(int unsigned p);
    return clip(blk_prev[clip(p)]);
  endfunction

  function automatic grant_t predict_alloc(int unsigned req);
    grant_t      g;
    int unsigned need, cand, scan, stop, spare, tail, after, laps;
    g = '{nfca_pkg::ST_OK, '0, '0};
    need = (req + nfca_pkg::HEADER_GRANULES * 8 + nfca_pkg::GUARD_BYTES + 7) >> 3;
    cand = clip(rover);
    scan = cand;
    stop = prev_blk(cand);
    laps = 0;
    // one lap from the rover; cand only moves past used blocks
    do begin
      if (scan == stop || laps > ZONE + 2) begin
        g.status = nfca_pkg::ST_NO_SPACE;
        return g;
      end
      laps++;
      if (blk_used[scan]) begin
        scan = next_blk(scan);
        cand = scan;
      end else begin
        scan = next_blk(scan);
      end
    end while (blk_used[cand] || blk_len[cand] < need);
    spare = blk_len[cand] - need;
    if (spare * 8 > nfca_pkg::SPLIT_MIN_BYTES) begin
      tail = cand + need;
      after = next_blk(cand);
      blk_len[tail] = spare;
      blk_used[tail] = 0;
      blk_prev[tail] = cand;
      blk_mark[tail] = 1;
      blk_prev[after] = tail;
      blk_len[cand] = need;
    end
    blk_used[cand] = 1;
    rover = next_blk(cand);
    g.addr = IDX_W'(cand + nfca_pkg::HEADER_GRANULES);
    g.gran = LEN_W'(blk_len[cand]);
    return g;
  endfunction

  function automatic grant_t predict_free(int unsigned addr);
    grant_t      g;
    int unsigned blk, nb, after;
    g = '{nfca_pkg::ST_OK, '0, '0};
    if (addr < nfca_pkg::HEADER_GRANULES) begin
      g.status = nfca_pkg::ST_NOT_START;
      return g;
    end
    blk = addr - nfca_pkg::HEADER_GRANULES;
    if (blk >= ZONE || !blk_mark[blk]) begin
      g.status = nfca_pkg::ST_NOT_START;
      return g;
    end
    if (!blk_used[blk]) begin
      g.status = nfca_pkg::ST_ALREADY_FREE;
      return g;
    end
    blk_used[blk] = 0;
    nb = prev_blk(blk);
    if (!blk_used[nb]) begin
      after = next_blk(blk);
      blk_len[nb] += blk_len[blk];
      blk_prev[after] = nb;
      if (rover == blk) rover = nb;
      blk_mark[blk] = 0;
      blk = nb;
    end
    nb = next_blk(blk);
    if (!blk_used[nb]) begin
      after = next_blk(nb);
      blk_len[blk] += blk_len[nb];
      blk_prev[after] = blk;
      if (rover == nb) rover = blk;
      blk_mark[nb] = 0;
    end
    return g;
  endfunction

  task automatic report(string what, longint exp_v, longint got_v);
    $display("MISMATCH @%0t %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && start && !busy) begin
      if (in_kind == nfca_pkg::KIND_FREE) g = predict_free(in_free_address);
      else g = predict_alloc(in_request_bytes);
      pending_grants.push_back(g);
    end
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        report("result with no command outstanding", 0, 1);
      end else begin
        g = pending_grants.pop_front();
        case (g.status)
          nfca_pkg::ST_OK:       if (g.gran != 0) n_granted++; else n_freed++;
          nfca_pkg::ST_NO_SPACE: n_no_space++;
          default:               n_rejected++;
        endcase
        if (out_status != g.status) report("status", g.status, out_status);
        if (out_granted_address != g.addr)
          report("granted address", g.addr, out_granted_address);
        if (out_granted_granules != g.gran)
          report("granted granules", g.gran, out_granted_granules);
      end
    end
  end

endmodule

>>> verif/next_fit_coalescing_allocator_tb.sv
module next_fit_coalescing_allocator_tb;

  localparam int STALL_LIMIT = 400000;
  localparam int N_RANDOM = 1080;
  localparam int REQ_W = nfca_pkg::REQ_W;
  localparam int IDX_W = nfca_pkg::IDX_W;
  localparam int LEN_W = nfca_pkg::LEN_W;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_kind;
  logic [REQ_W-1:0] in_request_bytes;
  logic [IDX_W-1:0] in_free_address;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_granted_address;
  logic [LEN_W-1:0] out_granted_granules;

  int errors, waiting, n_granted, n_no_space, n_freed, n_rejected;
  int quiet_cycles = 0;
  int idle_pct;

  logic [IDX_W-1:0] live_blocks[$];
  logic [IDX_W-1:0] dead_blocks[$];

  next_fit_coalescing_allocator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_request_bytes(in_request_bytes),
    .in_free_address(in_free_address), .out_valid(out_valid),
    .out_status(out_status), .out_granted_address(out_granted_address),
    .out_granted_granules(out_granted_granules)
  );

  next_fit_coalescing_allocator_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_request_bytes(in_request_bytes),
    .in_free_address(in_free_address), .out_valid(out_valid),
    .out_status(out_status), .out_granted_address(out_granted_address),
    .out_granted_granules(out_granted_granules),
    .errors(errors), .waiting(waiting), .n_granted(n_granted),
    .n_no_space(n_no_space), .n_freed(n_freed), .n_rejected(n_rejected)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // one command, then its result; start drops before the result strobe so
  // a low busy in that cycle cannot take the command twice
  task automatic run_cmd(input logic kind, input logic [REQ_W-1:0] req,
                         input logic [IDX_W-1:0] fa, output nfca_pkg::status_t st,
                         output logic [IDX_W-1:0] ga);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_request_bytes <= req;
    in_free_address <= fa;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
    in_request_bytes <= REQ_W'($urandom);
    in_free_address <= IDX_W'($urandom);
    while (!out_valid) @(posedge clk);
    st = nfca_pkg::status_t'(out_status);
    ga = out_granted_address;
    if (kind == nfca_pkg::KIND_ALLOC && st == nfca_pkg::ST_OK) live_blocks.push_back(ga);
    gap = ($urandom_range(99, 0) < idle_pct) ? $urandom_range(6, 1) : 0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic alloc_cmd(input logic [REQ_W-1:0] req);
    nfca_pkg::status_t st;
    logic [IDX_W-1:0] ga;
    run_cmd(nfca_pkg::KIND_ALLOC, req, '0, st, ga);
  endtask

  task automatic free_cmd(input logic [IDX_W-1:0] fa);
    nfca_pkg::status_t st;
    logic [IDX_W-1:0] ga;
    run_cmd(nfca_pkg::KIND_FREE, '0, fa, st, ga);
  endtask

  task automatic random_cmd();
    int sel, idx;
    logic [IDX_W-1:0] a;
    sel = $urandom_range(99, 0);
    if (live_blocks.size() > 60 || (live_blocks.size() > 0 && sel < 40)) begin
      idx = $urandom_range(live_blocks.size() - 1, 0);
      a = live_blocks[idx];
      live_blocks.delete(idx);
      dead_blocks.push_back(a);
      if (dead_blocks.size() > 40) void'(dead_blocks.pop_front());
      free_cmd(a);
    end else if (sel < 48) begin
      free_cmd(IDX_W'($urandom));
    end else if (sel < 54 && dead_blocks.size() > 0) begin
      free_cmd(dead_blocks[$urandom_range(dead_blocks.size() - 1, 0)]);
    end else if (sel < 58 && live_blocks.size() > 0) begin
      free_cmd(live_blocks[$urandom_range(live_blocks.size() - 1, 0)] +
               IDX_W'($urandom_range(3, 1)));
    end else if (sel < 64) begin
      alloc_cmd(REQ_W'($urandom));
    end else if (sel < 72) begin
      alloc_cmd(REQ_W'($urandom_range(60000, 4000)));
    end else begin
      alloc_cmd(REQ_W'($urandom_range(2000, 0)));
    end
  endtask

  initial begin
    nfca_pkg::status_t st;
    logic [IDX_W-1:0] a0, a1, a2;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = nfca_pkg::KIND_ALLOC;
    in_request_bytes = '0;
    in_free_address = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: size extremes, bad frees, double free, absorbed block
    run_cmd(nfca_pkg::KIND_ALLOC, '0, '0, st, a0);
    run_cmd(nfca_pkg::KIND_ALLOC, REQ_W'(100), '0, st, a1);
    run_cmd(nfca_pkg::KIND_ALLOC, REQ_W'(24), '0, st, a2);
    alloc_cmd('1);
    alloc_cmd(REQ_W'(nfca_pkg::ZONE_GRANULES * 8 - 100));
    free_cmd('0);
    free_cmd(IDX_W'(nfca_pkg::HEADER_GRANULES - 1));
    free_cmd('1);
    free_cmd(a1 + 1'b1);
    free_cmd(a1);
    free_cmd(a1);
    free_cmd(a0);
    free_cmd(a1);
    free_cmd(a0);
    free_cmd(a2);
    live_blocks.delete();
    alloc_cmd(REQ_W'(200000));
    alloc_cmd(REQ_W'(200000));
    alloc_cmd(REQ_W'(200000));
    alloc_cmd(REQ_W'(5));
    while (live_blocks.size() > 0) free_cmd(live_blocks.pop_front());

    for (int i = 0; i < N_RANDOM; i++) begin
      case (i * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 10;
        default: idle_pct = 0;
      endcase
      random_cmd();
    end

    while (waiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d grants, %0d no-space, %0d frees, %0d rejected frees",
             n_granted, n_no_space, n_freed, n_rejected);
    $display("Sender gaps varied from none to 46 percent across phases");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
